/* rtl/qvr_pkg.sv */
// shared types, widths and constants of the quaternion vector rotate unit
// used by every module under rtl; depends on nothing else
`default_nettype none

package qvr_pkg;

    // field and datapath widths
    localparam int QW   = 32;           // quaternion and vector component
    localparam int S1W  = 66;           // sum of three 64-bit products
    localparam int SH1  = 16;           // first rounding shift
    localparam int TW   = 49;           // first product component after rounding
    localparam int TLW  = 17;           // low slice of a first product component
    localparam int THW  = TW - TLW;     // high slice, signed
    localparam int PHW  = 2 * QW;       // high partial product
    localparam int PLW  = TLW + 1 + QW; // low partial product
    localparam int PW   = 81;           // full second-stage product
    localparam int SW   = 83;           // sum of four full products
    localparam int SH2  = 44;           // second rounding shift
    localparam int RW   = SW - SH2;     // rounded result before saturation
    localparam int NSTG = 6;            // register stages

    // rounding constants, halves go toward plus infinity
    localparam logic signed [S1W-1:0] RND1 = S1W'(1) <<< (SH1 - 1);
    localparam logic signed [SW-1:0]  RND2 = SW'(1) <<< (SH2 - 1);

    // saturation bounds
    localparam logic signed [QW-1:0] SAT_MAX = {1'b0, {(QW - 1){1'b1}}};
    localparam logic signed [QW-1:0] SAT_MIN = {1'b1, {(QW - 1){1'b0}}};

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_QUAT_X = 2'd0,
        CFG_QUAT_Y = 2'd1,
        CFG_QUAT_Z = 2'd2,
        CFG_QUAT_W = 2'd3
    } t_cfg_idx;

    localparam logic signed [QW-1:0] QUAT_W_RESET = QW'(32'h4000_0000);

    // payload of one input item
    typedef struct packed {
        logic signed [QW-1:0] vec_x;
        logic signed [QW-1:0] vec_y;
        logic signed [QW-1:0] vec_z;
    } t_vec_in;

    // payload of one result item
    typedef struct packed {
        logic signed [QW-1:0] rot_x;
        logic signed [QW-1:0] rot_y;
        logic signed [QW-1:0] rot_z;
        logic                 clipped;
    } t_rot_out;

    // quaternion held in the configuration registers
    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] w;
    } t_quat;

    // first product q * v, rounded to 30 fraction bits
    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
        logic signed [TW-1:0] w;
    } t_tvec;

    // rounded vector before saturation
    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } t_rvec;

    // load enables of the register stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    // 32 x 32 signed multiply
    function automatic logic signed [PHW-1:0] smul_hi(input logic signed [QW-1:0] a,
                                                      input logic signed [QW-1:0] b);
        smul_hi = a * b;
    endfunction

    // 18 x 32 signed multiply, the low slice carries a zero sign bit
    function automatic logic signed [PLW-1:0] smul_lo(input logic signed [TLW:0] a,
                                                      input logic signed [QW-1:0] b);
        smul_lo = a * b;
    endfunction

endpackage

`default_nettype wire

/* rtl/qvr_pipe_ctrl.sv */
// valid bits and stage load enables of the six-stage pipeline
// depends on qvr_pkg
`default_nettype none

module qvr_pipe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output qvr_pkg::t_pipe_en     o_en
);

    logic [qvr_pkg::NSTG-1:0] r_vld;
    logic [qvr_pkg::NSTG-1:0] n_vld;
    logic [qvr_pkg::NSTG-1:0] rdy;

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        rdy[qvr_pkg::NSTG-1] = !r_vld[qvr_pkg::NSTG-1] || i_out_ready;
        for (int k = qvr_pkg::NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
    end

    // next valid bits
    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < qvr_pkg::NSTG; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // enables out to the datapath
    always_comb begin
        o_en.s1 = rdy[0];
        o_en.s2 = rdy[1];
        o_en.s3 = rdy[2];
        o_en.s4 = rdy[3];
        o_en.s5 = rdy[4];
        o_en.s6 = rdy[5];
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[qvr_pkg::NSTG-1];

endmodule

`default_nettype wire

/* rtl/qvr_tmul.sv */
// first quaternion product t = q * v over two register stages
// depends on qvr_pkg
`default_nettype none

module qvr_tmul (
    input  wire logic             i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_vec_in i_vec,
    input  wire qvr_pkg::t_quat   i_quat,
    output qvr_pkg::t_tvec        o_t
);

    logic signed [qvr_pkg::PHW-1:0] r_p [0:11];
    logic signed [qvr_pkg::S1W-1:0] s_x;
    logic signed [qvr_pkg::S1W-1:0] s_y;
    logic signed [qvr_pkg::S1W-1:0] s_z;
    logic signed [qvr_pkg::S1W-1:0] s_w;
    qvr_pkg::t_tvec                 r_t;

    // stage 1: twelve 32 x 32 products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p[0]  <= qvr_pkg::smul_hi(i_vec.vec_x, i_quat.w);
            r_p[1]  <= qvr_pkg::smul_hi(i_vec.vec_z, i_quat.y);
            r_p[2]  <= qvr_pkg::smul_hi(i_vec.vec_y, i_quat.z);
            r_p[3]  <= qvr_pkg::smul_hi(i_vec.vec_y, i_quat.w);
            r_p[4]  <= qvr_pkg::smul_hi(i_vec.vec_x, i_quat.z);
            r_p[5]  <= qvr_pkg::smul_hi(i_vec.vec_z, i_quat.x);
            r_p[6]  <= qvr_pkg::smul_hi(i_vec.vec_z, i_quat.w);
            r_p[7]  <= qvr_pkg::smul_hi(i_vec.vec_y, i_quat.x);
            r_p[8]  <= qvr_pkg::smul_hi(i_vec.vec_x, i_quat.y);
            r_p[9]  <= qvr_pkg::smul_hi(i_vec.vec_x, i_quat.x);
            r_p[10] <= qvr_pkg::smul_hi(i_vec.vec_y, i_quat.y);
            r_p[11] <= qvr_pkg::smul_hi(i_vec.vec_z, i_quat.z);
        end
    end

    // exact sums with the rounding half added
    always_comb begin
        s_x = qvr_pkg::S1W'(r_p[0]) + qvr_pkg::S1W'(r_p[1]) - qvr_pkg::S1W'(r_p[2])
            + qvr_pkg::RND1;
        s_y = qvr_pkg::S1W'(r_p[3]) + qvr_pkg::S1W'(r_p[4]) - qvr_pkg::S1W'(r_p[5])
            + qvr_pkg::RND1;
        s_z = qvr_pkg::S1W'(r_p[6]) + qvr_pkg::S1W'(r_p[7]) - qvr_pkg::S1W'(r_p[8])
            + qvr_pkg::RND1;
        s_w = qvr_pkg::RND1 - qvr_pkg::S1W'(r_p[9]) - qvr_pkg::S1W'(r_p[10])
            - qvr_pkg::S1W'(r_p[11]);
    end

    // stage 2: shift down to 30 fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_t.x <= qvr_pkg::TW'(s_x >>> qvr_pkg::SH1);
            r_t.y <= qvr_pkg::TW'(s_y >>> qvr_pkg::SH1);
            r_t.z <= qvr_pkg::TW'(s_z >>> qvr_pkg::SH1);
            r_t.w <= qvr_pkg::TW'(s_w >>> qvr_pkg::SH1);
        end
    end

    assign o_t = r_t;

endmodule

`default_nettype wire

/* rtl/qvr_rmul.sv */
// second product r = t * conj(q), vector part, over three register stages
// depends on qvr_pkg
`default_nettype none

module qvr_rmul (
    input  wire logic              i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_tvec    i_t,
    input  wire qvr_pkg::t_quat    i_quat,
    output qvr_pkg::t_rvec         o_r
);

    logic signed [qvr_pkg::TW-1:0]  ta [0:11];
    logic signed [qvr_pkg::QW-1:0]  qa [0:11];
    logic signed [qvr_pkg::PHW-1:0] r_ph [0:11];
    logic signed [qvr_pkg::PLW-1:0] r_pl [0:11];
    logic signed [qvr_pkg::PW-1:0]  r_pf [0:11];
    logic signed [qvr_pkg::SW-1:0]  s [0:2];
    qvr_pkg::t_rvec                 r_r;

    // operand pairs, per component: -tw*q, +t*w, -t*q, +t*q
    always_comb begin
        ta[0]  = i_t.w;  qa[0]  = i_quat.x;
        ta[1]  = i_t.x;  qa[1]  = i_quat.w;
        ta[2]  = i_t.y;  qa[2]  = i_quat.z;
        ta[3]  = i_t.z;  qa[3]  = i_quat.y;
        ta[4]  = i_t.w;  qa[4]  = i_quat.y;
        ta[5]  = i_t.y;  qa[5]  = i_quat.w;
        ta[6]  = i_t.z;  qa[6]  = i_quat.x;
        ta[7]  = i_t.x;  qa[7]  = i_quat.z;
        ta[8]  = i_t.w;  qa[8]  = i_quat.z;
        ta[9]  = i_t.z;  qa[9]  = i_quat.w;
        ta[10] = i_t.x;  qa[10] = i_quat.y;
        ta[11] = i_t.y;  qa[11] = i_quat.x;
    end

    // stage 3: split each t into a signed high slice and an unsigned low slice and multiply each by q
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int k = 0; k < 12; k++) begin
                r_ph[k] <= qvr_pkg::smul_hi(ta[k][qvr_pkg::TW-1:qvr_pkg::TLW], qa[k]);
                r_pl[k] <= qvr_pkg::smul_lo({1'b0, ta[k][qvr_pkg::TLW-1:0]}, qa[k]);
            end
        end
    end

    // stage 4: recombine the partial products
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            for (int k = 0; k < 12; k++) begin
                r_pf[k] <= (qvr_pkg::PW'(r_ph[k]) <<< qvr_pkg::TLW) + qvr_pkg::PW'(r_pl[k]);
            end
        end
    end

    // signed sums of four with the rounding half
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s[c] = qvr_pkg::RND2 - qvr_pkg::SW'(r_pf[4 * c]) + qvr_pkg::SW'(r_pf[4 * c + 1])
                 - qvr_pkg::SW'(r_pf[4 * c + 2]) + qvr_pkg::SW'(r_pf[4 * c + 3]);
        end
    end

    // stage 5: shift down to 16 fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_r.x <= qvr_pkg::RW'(s[0] >>> qvr_pkg::SH2);
            r_r.y <= qvr_pkg::RW'(s[1] >>> qvr_pkg::SH2);
            r_r.z <= qvr_pkg::RW'(s[2] >>> qvr_pkg::SH2);
        end
    end

    assign o_r = r_r;

endmodule

`default_nettype wire

/* rtl/qvr_sat.sv */
// saturation to 32 bits and the output register of the result item
// depends on qvr_pkg
`default_nettype none

module qvr_sat (
    input  wire logic              i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_rvec    i_r,
    output qvr_pkg::t_rot_out      o_rot
);

    logic signed [qvr_pkg::RW-1:0] comp [0:2];
    logic signed [qvr_pkg::QW-1:0] sat  [0:2];
    logic [2:0]                    clip;
    qvr_pkg::t_rot_out             r_rot;

    // in range when every bit above bit 30 matches the sign
    always_comb begin
        comp[0] = i_r.x;
        comp[1] = i_r.y;
        comp[2] = i_r.z;
        for (int c = 0; c < 3; c++) begin
            clip[c] = !((&comp[c][qvr_pkg::RW-1:qvr_pkg::QW-1])
                     || !(|comp[c][qvr_pkg::RW-1:qvr_pkg::QW-1]));
            if (!clip[c]) begin
                sat[c] = comp[c][qvr_pkg::QW-1:0];
            end else if (comp[c][qvr_pkg::RW-1]) begin
                sat[c] = qvr_pkg::SAT_MIN;
            end else begin
                sat[c] = qvr_pkg::SAT_MAX;
            end
        end
    end

    // stage 6: output register
    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_rot.rot_x   <= sat[0];
            r_rot.rot_y   <= sat[1];
            r_rot.rot_z   <= sat[2];
            r_rot.clipped <= |clip;
        end
    end

    assign o_rot = r_rot;

endmodule

`default_nettype wire

/* rtl/quaternion_vector_rotate_unit.sv */
// top level of the quaternion vector rotate unit: configuration registers,
// pipeline control and the three datapath sections; depends on qvr_pkg
//
// Rotates one Q16.16 vector per item by the Q2.30 quaternion in the four
// configuration registers (q * v * conj(q), not normalized, so a non-unit
// quaternion also scales by its squared norm), rounding each component to
// Q16.16 and saturating it to 32 bits, with clipped set when any component
// saturated. The pipeline has six register stages and takes one item every
// cycle unless every stage is full and the output stalls. Stage 1 forms
// twelve 32 x 32 products of the first quaternion product, stage 2 sums and
// rounds them, stages 3 and 4 form the twelve second-stage products from
// 32 x 32 and 18 x 32 partial products, stage 5 sums and rounds, and stage 6
// saturates into the output register. Backpressure stalls only the stages
// behind a full one, so empty slots fill while a result waits. Write the
// quaternion only while no item is in flight.
`default_nettype none

module quaternion_vector_rotate_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_vec_valid,
    output logic                   o_vec_ready,
    input  wire qvr_pkg::t_vec_in  i_vec,
    output logic                   o_rot_valid,
    input  wire logic              i_rot_ready,
    output qvr_pkg::t_rot_out      o_rot
);

    qvr_pkg::t_quat    r_quat;
    qvr_pkg::t_pipe_en en;
    qvr_pkg::t_tvec    t_mid;
    qvr_pkg::t_rvec    r_mid;

    // quaternion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_quat.w <= qvr_pkg::QUAT_W_RESET;
        end else if (i_cfg_we) begin
            case (qvr_pkg::t_cfg_idx'(i_cfg_idx))
                qvr_pkg::CFG_QUAT_X: r_quat.x <= i_cfg_data;
                qvr_pkg::CFG_QUAT_Y: r_quat.y <= i_cfg_data;
                qvr_pkg::CFG_QUAT_Z: r_quat.z <= i_cfg_data;
                qvr_pkg::CFG_QUAT_W: r_quat.w <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    qvr_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vec_valid),
        .o_in_ready  (o_vec_ready),
        .o_out_valid (o_rot_valid),
        .i_out_ready (i_rot_ready),
        .o_en        (en)
    );

    // first product
    qvr_tmul u_tmul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_vec  (i_vec),
        .i_quat (r_quat),
        .o_t    (t_mid)
    );

    // second product
    qvr_rmul u_rmul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_t    (t_mid),
        .i_quat (r_quat),
        .o_r    (r_mid)
    );

    // saturation and output register
    qvr_sat u_sat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_r   (r_mid),
        .o_rot (o_rot)
    );

    // an empty output stage means every stage can load
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_rot_valid |-> o_vec_ready
    ) else $error("input not ready while output stage is empty");

    // a clipped item carries at least one bound value
    a_clip_at_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rot_valid && o_rot.clipped) |->
            (o_rot.rot_x == qvr_pkg::SAT_MAX || o_rot.rot_x == qvr_pkg::SAT_MIN
             || o_rot.rot_y == qvr_pkg::SAT_MAX || o_rot.rot_y == qvr_pkg::SAT_MIN
             || o_rot.rot_z == qvr_pkg::SAT_MAX || o_rot.rot_z == qvr_pkg::SAT_MIN)
    ) else $error("clipped set with no saturated component");

    // a stalled output stage holds its item
    a_hold_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rot_valid && !i_rot_ready) |=> (o_rot_valid && $stable(o_rot))
    ) else $error("output item changed while stalled");

endmodule

`default_nettype wire

/* tb/sv/quaternion_vector_rotate_unit_test.sv */
// self-checking testbench of the quaternion vector rotate unit
// depends on qvr_pkg and quaternion_vector_rotate_unit under rtl
`default_nettype none

module quaternion_vector_rotate_unit_test;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RAND_PER_PHASE = 150;
    localparam int NUM_SETTINGS   = 10;

    // rounding constants of the predictor, 128-bit signed
    localparam logic signed [127:0] HALF_T = 128'sd1 <<< (qvr_pkg::SH1 - 1);
    localparam logic signed [127:0] HALF_R = 128'sd1 <<< (qvr_pkg::SH2 - 1);

    // q = 1.0 and q = 0.5 in Q2.30
    localparam logic [31:0] Q_ONE  = 32'h4000_0000;
    localparam logic [31:0] Q_HALF = 32'h2000_0000;
    // cos(45 deg) in Q2.30, for a 90 deg turn about z
    localparam logic [31:0] Q_C45  = 32'd759250125;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    qvr_pkg::t_cfg_idx i_cfg_idx;
    logic [31:0]       i_cfg_data;
    logic              i_vec_valid;
    logic              o_vec_ready;
    qvr_pkg::t_vec_in  i_vec;
    logic              o_rot_valid;
    logic              i_rot_ready;
    qvr_pkg::t_rot_out o_rot;

    // idle rates in percent, changed per phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // expected rotations and the quaternion they are computed with
    class rotation_scoreboard;
        qvr_pkg::t_quat    quat;
        qvr_pkg::t_rot_out expected_rot[$];
        int unsigned errors;

        function new();
            quat = '{x: '0, y: '0, z: '0, w: qvr_pkg::QUAT_W_RESET};
            errors = 0;
        endfunction

        function void set_register(qvr_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                qvr_pkg::CFG_QUAT_X: quat.x = data;
                qvr_pkg::CFG_QUAT_Y: quat.y = data;
                qvr_pkg::CFG_QUAT_Z: quat.z = data;
                qvr_pkg::CFG_QUAT_W: quat.w = data;
                default: ;
            endcase
        endfunction

        // clamp to the 32-bit range and flag a clamp
        function logic [31:0] clamp_q16(logic signed [127:0] r, inout logic clip);
            if (r > qvr_pkg::SAT_MAX) begin
                clip = 1'b1;
                return qvr_pkg::SAT_MAX;
            end
            if (r < qvr_pkg::SAT_MIN) begin
                clip = 1'b1;
                return qvr_pkg::SAT_MIN;
            end
            return r[31:0];
        endfunction

        // q * v * conj(q) with exact sums and round half up
        function qvr_pkg::t_rot_out rotate_vector(qvr_pkg::t_vec_in v);
            logic signed [127:0] qx, qy, qz, qw, vx, vy, vz;
            logic signed [127:0] tx, ty, tz, tw, rx, ry, rz;
            qvr_pkg::t_rot_out res;
            qx = $signed(quat.x);
            qy = $signed(quat.y);
            qz = $signed(quat.z);
            qw = $signed(quat.w);
            vx = $signed(v.vec_x);
            vy = $signed(v.vec_y);
            vz = $signed(v.vec_z);
            // first product, 46 fraction bits down to 30
            tx = (vx * qw + vz * qy - vy * qz + HALF_T) >>> qvr_pkg::SH1;
            ty = (vy * qw + vx * qz - vz * qx + HALF_T) >>> qvr_pkg::SH1;
            tz = (vz * qw + vy * qx - vx * qy + HALF_T) >>> qvr_pkg::SH1;
            tw = (HALF_T - vx * qx - vy * qy - vz * qz) >>> qvr_pkg::SH1;
            // second product with the conjugate, 60 fraction bits down to 16
            rx = (tx * qw - tw * qx - ty * qz + tz * qy + HALF_R) >>> qvr_pkg::SH2;
            ry = (ty * qw - tw * qy - tz * qx + tx * qz + HALF_R) >>> qvr_pkg::SH2;
            rz = (tz * qw - tw * qz - tx * qy + ty * qx + HALF_R) >>> qvr_pkg::SH2;
            res.clipped = 1'b0;
            res.rot_x = clamp_q16(rx, res.clipped);
            res.rot_y = clamp_q16(ry, res.clipped);
            res.rot_z = clamp_q16(rz, res.clipped);
            return res;
        endfunction

        function void note_vector(qvr_pkg::t_vec_in v);
            expected_rot.push_back(rotate_vector(v));
        endfunction

        function void check_rotation(qvr_pkg::t_rot_out got);
            qvr_pkg::t_rot_out want;
            if (expected_rot.size() == 0) begin
                $error("rotation item with no vector pending: %h", got);
                errors++;
                return;
            end
            want = expected_rot.pop_front();
            if (got.rot_x !== want.rot_x) begin
                $error("rot_x mismatch: expected %h, actual %h", want.rot_x, got.rot_x);
                errors++;
            end
            if (got.rot_y !== want.rot_y) begin
                $error("rot_y mismatch: expected %h, actual %h", want.rot_y, got.rot_y);
                errors++;
            end
            if (got.rot_z !== want.rot_z) begin
                $error("rot_z mismatch: expected %h, actual %h", want.rot_z, got.rot_z);
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped mismatch: expected %b, actual %b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    rotation_scoreboard sb = new();

    quaternion_vector_rotate_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vec_valid (i_vec_valid),
        .o_vec_ready (o_vec_ready),
        .i_vec       (i_vec),
        .o_rot_valid (o_rot_valid),
        .i_rot_ready (i_rot_ready),
        .o_rot       (o_rot)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // one vector component: corners, small values or any pattern
    function automatic logic [31:0] rand_component();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2, 3: return 32'($urandom_range(2097151)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic qvr_pkg::t_vec_in rand_vec();
        qvr_pkg::t_vec_in v;
        v.vec_x = rand_component();
        v.vec_y = rand_component();
        v.vec_z = rand_component();
        return v;
    endfunction

    // quaternion component from -1.0 up to just under 1.0 in Q2.30
    function automatic logic [31:0] rand_unitish();
        return 32'($urandom_range(32'h7FFF_FFFF)) - Q_ONE;
    endfunction

    // one item on the vector channel, entered and left at a falling edge
    task automatic send_vector(input qvr_pkg::t_vec_in v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_vec_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_vec_valid <= 1'b1;
        i_vec <= v;
        do @(posedge i_clk); while (!o_vec_ready);
        sb.note_vector(v);
        @(negedge i_clk);
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        qvr_pkg::t_vec_in v;
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        send_vector(v);
    endtask

    // stop sending and wait for every pending rotation
    task automatic drain();
        i_vec_valid <= 1'b0;
        while (sb.expected_rot.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input qvr_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic write_quat(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w);
        write_reg(qvr_pkg::CFG_QUAT_X, x);
        write_reg(qvr_pkg::CFG_QUAT_Y, y);
        write_reg(qvr_pkg::CFG_QUAT_Z, z);
        write_reg(qvr_pkg::CFG_QUAT_W, w);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: write_quat(32'h0, 32'h0, 32'h0, Q_ONE);
            1: write_quat(32'h0, 32'h0, Q_C45, Q_C45);
            2: write_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            3: write_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            4: write_quat(32'h0, 32'h0, 32'h0, 32'h0);
            5: write_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
            6: write_quat($urandom(), $urandom(), $urandom(), $urandom());
            7, 8: write_quat(rand_unitish(), rand_unitish(), rand_unitish(), rand_unitish());
            default: write_quat(32'($urandom_range(65535)), 32'hFFFF_0000,
                                32'($urandom_range(255)), Q_HALF);
        endcase
    endtask

    // idle pattern of a phase: none, sender, receiver, both lightly
    task automatic set_idle_mode(input int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endtask

    // result side: check at the rising edge, new ready at the falling edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rot_valid && i_rot_ready) sb.check_rotation(o_rot);
            @(negedge i_clk);
            i_rot_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= qvr_pkg::CFG_QUAT_X;
        i_cfg_data  <= '0;
        i_vec_valid <= 1'b0;
        i_vec       <= '0;
        i_rot_ready <= 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset quaternion is identity: corners, zero, unit steps
        set_idle_mode(0);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h0, 32'h0, 32'h0);
        send_xyz(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_xyz(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // half scale quaternion: halves in the last rounding go up
        write_quat(32'h0, 32'h0, 32'h0, Q_HALF);
        send_xyz(32'd2, 32'hFFFF_FFFE, 32'd6);
        send_xyz(32'hFFFF_FFFA, 32'd1, 32'hFFFF_FFFF);
        send_xyz(32'h7FFF_FFFE, 32'h8000_0002, 32'd10);
        send_xyz(32'hFFFF_FFF6, 32'd14, 32'hFFFF_FFF2);
        drain();

        // full-scale quaternion: clamping on both sides
        write_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h7FFF_FFFF, 32'h0, 32'h0);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_xyz(32'h0000_0001, 32'h0, 32'h0);
        send_xyz(32'h0, 32'h0, 32'h0);
        drain();

        // random vectors under a sequence of quaternions and idle patterns
        for (int k = 0; k < NUM_SETTINGS; k++) begin
            set_idle_mode(k);
            apply_setting(k);
            repeat (RAND_PER_PHASE) send_vector(rand_vec());
            drain();
        end

        // let any stray item show up
        repeat (qvr_pkg::NSTG + 4) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_rot.size() == 0) begin
            $display("quaternion_vector_rotate_unit regression: pass");
        end else begin
            $display("quaternion_vector_rotate_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("quaternion_vector_rotate_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/qvr_pkg.sv
rtl/qvr_pipe_ctrl.sv
rtl/qvr_tmul.sv
rtl/qvr_rmul.sv
rtl/qvr_sat.sv
rtl/quaternion_vector_rotate_unit.sv
tb/sv/quaternion_vector_rotate_unit_test.sv
